>>> rtl/vat_pkg.sv
// vat_pkg: shared widths, codes and structs of the vertex affine transform
// used by vat_operand_sel, vat_mac_lane and vertex_affine_transform
package vat_pkg;

  // data path widths
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int COEF_FRAC   = 16;

  // configuration register widths
  localparam int MODE_W     = 2;
  localparam int AXIS_W     = 2;
  localparam int OFS_W      = 32;
  localparam int SCALE_W    = 32;
  localparam int TRIG_W     = 18;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // operand and accumulator widths, wide enough for any product and sum
  localparam int OPA_W  = (COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W;
  localparam int CF_W   = ((SCALE_W > TRIG_W) ? SCALE_W : TRIG_W) + 1;
  localparam int PROD_W = OPA_W + CF_W;
  localparam int SUM_W  = PROD_W + 2;

  // stream payload
  localparam int NUM_AXES = 3;
  localparam int TDATA_RAW_W = NUM_AXES * COORD_WIDTH;
  localparam int TDATA_W = ((TDATA_RAW_W + 7) / 8) * 8;

  // pipeline depth from input register to output register
  localparam int NUM_STAGES = 5;

  // reset values
  localparam logic signed [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) <<< FRAC_BITS;
  localparam logic signed [TRIG_W-1:0]  COS_RESET   = TRIG_W'(1) <<< COEF_FRAC;

  typedef enum logic [MODE_W-1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2
  } mode_e;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_AXIS     = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_OFFSET_Z = 3'd4,
    REG_SCALE    = 3'd5,
    REG_COS      = 3'd6,
    REG_SIN      = 3'd7
  } reg_idx_e;

  // rounding applied before the final shift
  typedef enum logic [1:0] {
    RND_NONE = 2'd0,
    RND_FRAC = 2'd1,
    RND_COEF = 2'd2
  } rnd_e;

  typedef struct packed {
    mode_e                     mode;
    axis_e                     axis;
    logic signed [OFS_W-1:0]   offset_x;
    logic signed [OFS_W-1:0]   offset_y;
    logic signed [OFS_W-1:0]   offset_z;
    logic signed [SCALE_W-1:0] scale;
    logic signed [TRIG_W-1:0]  cos_c;
    logic signed [TRIG_W-1:0]  sin_c;
  } cfg_t;

  // operands of one output coordinate: a*ca + b*cb, or a + b without multiply
  typedef struct packed {
    logic signed [OPA_W-1:0] a;
    logic signed [CF_W-1:0]  ca;
    logic signed [OPA_W-1:0] b;
    logic signed [CF_W-1:0]  cb;
    logic                    use_mul;
    rnd_e                    rnd;
  } lane_op_t;

  // load enables of the lane stages
  typedef struct packed {
    logic op;
    logic mul;
    logic add;
    logic sat;
  } stage_en_t;

endpackage

>>> rtl/vat_operand_sel.sv
// vat_operand_sel: picks multiplier operands of all three lanes from mode and axis
// depends on vat_pkg
module vat_operand_sel (
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] x_i,
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] y_i,
  input  logic signed [vat_pkg::COORD_WIDTH-1:0] z_i,
  input  vat_pkg::cfg_t                          cfg_i,
  output vat_pkg::lane_op_t                      op_x_o,
  output vat_pkg::lane_op_t                      op_y_o,
  output vat_pkg::lane_op_t                      op_z_o
);

  logic signed [vat_pkg::OPA_W-1:0] xa, ya, za;
  logic signed [vat_pkg::CF_W-1:0]  c_c, s_c, ns_c, sc_c;

  assign xa   = vat_pkg::OPA_W'(x_i);
  assign ya   = vat_pkg::OPA_W'(y_i);
  assign za   = vat_pkg::OPA_W'(z_i);
  assign c_c  = vat_pkg::CF_W'(cfg_i.cos_c);
  assign s_c  = vat_pkg::CF_W'(cfg_i.sin_c);
  assign ns_c = -s_c;
  assign sc_c = vat_pkg::CF_W'(cfg_i.scale);

  // plain pass of a coordinate
  function automatic vat_pkg::lane_op_t pass_op(input logic signed [vat_pkg::OPA_W-1:0] v);
    vat_pkg::lane_op_t r;
    r.a       = v;
    r.ca      = '0;
    r.b       = '0;
    r.cb      = '0;
    r.use_mul = 1'b0;
    r.rnd     = vat_pkg::RND_NONE;
    return r;
  endfunction

  function automatic vat_pkg::lane_op_t mac_op(
    input logic signed [vat_pkg::OPA_W-1:0] a,
    input logic signed [vat_pkg::CF_W-1:0]  ca,
    input logic signed [vat_pkg::OPA_W-1:0] b,
    input logic signed [vat_pkg::CF_W-1:0]  cb,
    input vat_pkg::rnd_e                    rnd
  );
    vat_pkg::lane_op_t r;
    r.a       = a;
    r.ca      = ca;
    r.b       = b;
    r.cb      = cb;
    r.use_mul = 1'b1;
    r.rnd     = rnd;
    return r;
  endfunction

  always_comb begin
    op_x_o = pass_op(xa);
    op_y_o = pass_op(ya);
    op_z_o = pass_op(za);
    case (cfg_i.mode)
      vat_pkg::MODE_TRANSLATE: begin
        op_x_o.b = vat_pkg::OPA_W'(cfg_i.offset_x);
        op_y_o.b = vat_pkg::OPA_W'(cfg_i.offset_y);
        op_z_o.b = vat_pkg::OPA_W'(cfg_i.offset_z);
      end
      vat_pkg::MODE_SCALE: begin
        op_x_o = mac_op(xa, sc_c, '0, '0, vat_pkg::RND_FRAC);
        op_y_o = mac_op(ya, sc_c, '0, '0, vat_pkg::RND_FRAC);
        op_z_o = mac_op(za, sc_c, '0, '0, vat_pkg::RND_FRAC);
      end
      vat_pkg::MODE_ROTATE: begin
        case (cfg_i.axis)
          vat_pkg::AXIS_X: begin
            op_y_o = mac_op(ya, c_c, za, ns_c, vat_pkg::RND_COEF);
            op_z_o = mac_op(ya, s_c, za, c_c, vat_pkg::RND_COEF);
          end
          vat_pkg::AXIS_Y: begin
            op_x_o = mac_op(xa, c_c, za, s_c, vat_pkg::RND_COEF);
            op_z_o = mac_op(xa, ns_c, za, c_c, vat_pkg::RND_COEF);
          end
          vat_pkg::AXIS_Z: begin
            op_x_o = mac_op(xa, c_c, ya, ns_c, vat_pkg::RND_COEF);
            op_y_o = mac_op(xa, s_c, ya, c_c, vat_pkg::RND_COEF);
          end
          default: begin
            // unused axis code passes the vertex
          end
        endcase
      end
      default: begin
        // unused mode code passes the vertex
      end
    endcase
  end

endmodule

>>> rtl/vat_mac_lane.sv
// vat_mac_lane: one output coordinate, four stages of operand, multiply, add with rounding, shift and clamp
// depends on vat_pkg
module vat_mac_lane (
  input  logic                                   clk_i,
  input  vat_pkg::stage_en_t                     en_i,
  input  vat_pkg::lane_op_t                      op_i,
  output logic signed [vat_pkg::COORD_WIDTH-1:0] res_o
);

  localparam int SW = vat_pkg::SUM_W;
  localparam int CW = vat_pkg::COORD_WIDTH;

  localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  vat_pkg::lane_op_t                   op_q;
  logic signed [vat_pkg::PROD_W-1:0]   pa_d, pa_q, pb_d, pb_q;
  vat_pkg::rnd_e                       rnd_mul_q, rnd_add_q;
  logic signed [SW-1:0]                rc, sum_d, sum_q, shr;
  logic signed [CW-1:0]                res_d, res_q;

  // stage 1: operands
  always_ff @(posedge clk_i) begin
    if (en_i.op) begin
      op_q <= op_i;
    end
  end

  // stage 2: products
  always_comb begin
    if (op_q.use_mul) begin
      pa_d = op_q.a * op_q.ca;
      pb_d = op_q.b * op_q.cb;
    end else begin
      pa_d = vat_pkg::PROD_W'(op_q.a);
      pb_d = vat_pkg::PROD_W'(op_q.b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      rnd_mul_q <= op_q.rnd;
    end
  end

  // stage 3: exact sum plus half an lsb of the result
  always_comb begin
    case (rnd_mul_q)
      vat_pkg::RND_FRAC: rc = SW'(1) <<< (vat_pkg::FRAC_BITS - 1);
      vat_pkg::RND_COEF: rc = SW'(1) <<< (vat_pkg::COEF_FRAC - 1);
      default:           rc = '0;
    endcase
    sum_d = SW'(pa_q) + SW'(pb_q) + rc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.add) begin
      sum_q     <= sum_d;
      rnd_add_q <= rnd_mul_q;
    end
  end

  // stage 4: floor shift and clamp to the coordinate range
  always_comb begin
    case (rnd_add_q)
      vat_pkg::RND_FRAC: shr = sum_q >>> vat_pkg::FRAC_BITS;
      vat_pkg::RND_COEF: shr = sum_q >>> vat_pkg::COEF_FRAC;
      default:           shr = sum_q;
    endcase
    if (shr > SAT_HI) begin
      res_d = SAT_HI[CW-1:0];
    end else if (shr < SAT_LO) begin
      res_d = SAT_LO[CW-1:0];
    end else begin
      res_d = shr[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sat) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/vertex_affine_transform.sv
// vertex_affine_transform: top level with register file, valid chain and three lanes
// depends on vat_pkg, vat_operand_sel and vat_mac_lane
//
// usage
//   s_axis carries one vertex per item: tdata holds x, y, z (signed q16.16),
//   tlast marks the final vertex of a mesh. m_axis returns the transformed
//   vertex in the same layout, with tlast copied from the input item.
//   the write port sets mode, axis, offsets, scale and the rotation
//   coefficients; write it only while no item is in flight.
// stages and throughput
//   five register stages: input, operand select, multiply, add with rounding
//   offset, shift and clamp. one item per cycle is sustained while the
//   receiver keeps tready high; the multiply stage with two 32x33 products
//   per lane sets the cycle time.
// reset
//   rst_ni clears every valid bit and loads the register defaults
//   (translate, x axis, zero offsets, scale 1.0, cos 1.0, sin 0).
// stall
//   each stage loads when it is empty or the next one moves, so bubbles
//   close up while the receiver holds tready low; tready of the input
//   drops only when all five stages hold items. nothing is lost or repeated.
module vertex_affine_transform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave side, tdata fields from lsb: vertex_x, vertex_y, vertex_z
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [vat_pkg::TDATA_W-1:0]         s_axis_tdata,
  input  logic                                s_axis_tlast,
  // master side, tdata fields from lsb: result_x, result_y, result_z
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vat_pkg::TDATA_W-1:0]         m_axis_tdata,
  output logic                                m_axis_tlast,
  // register write port
  input  logic                                cfg_we_i,
  input  logic [vat_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [vat_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int CW = vat_pkg::COORD_WIDTH;
  localparam int NS = vat_pkg::NUM_STAGES;

  // register file
  vat_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= vat_pkg::MODE_TRANSLATE;
      cfg_q.axis     <= vat_pkg::AXIS_X;
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.offset_z <= '0;
      cfg_q.scale    <= vat_pkg::SCALE_RESET;
      cfg_q.cos_c    <= vat_pkg::COS_RESET;
      cfg_q.sin_c    <= '0;
    end else if (cfg_we_i) begin
      case (vat_pkg::reg_idx_e'(cfg_idx_i))
        vat_pkg::REG_MODE:     cfg_q.mode     <= vat_pkg::mode_e'(cfg_data_i[vat_pkg::MODE_W-1:0]);
        vat_pkg::REG_AXIS:     cfg_q.axis     <= vat_pkg::axis_e'(cfg_data_i[vat_pkg::AXIS_W-1:0]);
        vat_pkg::REG_OFFSET_X: cfg_q.offset_x <= cfg_data_i[vat_pkg::OFS_W-1:0];
        vat_pkg::REG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i[vat_pkg::OFS_W-1:0];
        vat_pkg::REG_OFFSET_Z: cfg_q.offset_z <= cfg_data_i[vat_pkg::OFS_W-1:0];
        vat_pkg::REG_SCALE:    cfg_q.scale    <= cfg_data_i[vat_pkg::SCALE_W-1:0];
        vat_pkg::REG_COS:      cfg_q.cos_c    <= cfg_data_i[vat_pkg::TRIG_W-1:0];
        vat_pkg::REG_SIN:      cfg_q.sin_c    <= cfg_data_i[vat_pkg::TRIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // valid chain: stage k loads when empty or when stage k+1 loads
  logic [NS-1:0] vld_q, en;

  always_comb begin
    en[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // input register
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic [NS-1:0]        last_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q <= s_axis_tdata[CW-1:0];
      y_q <= s_axis_tdata[2*CW-1:CW];
      z_q <= s_axis_tdata[3*CW-1:2*CW];
    end
  end

  // last flag rides beside the lanes
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= s_axis_tlast;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  // operand selection and lanes
  vat_pkg::lane_op_t  op_x, op_y, op_z;
  vat_pkg::stage_en_t lane_en;
  logic signed [CW-1:0] res_x, res_y, res_z;

  assign lane_en.op  = en[1];
  assign lane_en.mul = en[2];
  assign lane_en.add = en[3];
  assign lane_en.sat = en[4];

  vat_operand_sel u_sel (
    .x_i    (x_q),
    .y_i    (y_q),
    .z_i    (z_q),
    .cfg_i  (cfg_q),
    .op_x_o (op_x),
    .op_y_o (op_y),
    .op_z_o (op_z)
  );

  vat_mac_lane u_lane_x (
    .clk_i (clk_i),
    .en_i  (lane_en),
    .op_i  (op_x),
    .res_o (res_x)
  );

  vat_mac_lane u_lane_y (
    .clk_i (clk_i),
    .en_i  (lane_en),
    .op_i  (op_y),
    .res_o (res_y)
  );

  vat_mac_lane u_lane_z (
    .clk_i (clk_i),
    .en_i  (lane_en),
    .op_i  (op_z),
    .res_o (res_z)
  );

  // output
  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tlast  = last_q[NS-1];
  assign m_axis_tdata  = vat_pkg::TDATA_W'({res_z, res_y, res_x});

  // checks
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // input back-pressure only when the whole pipe is full and stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (vld_q == '1 && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  // an accepted item with nothing leaving adds one to the fill
  a_fill_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=> $countones(vld_q) == $past($countones(vld_q)) + 1)
    else $error("accepted item not counted in pipeline");

  // a delivered result with nothing entering removes one
  a_fill_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !in_acc) |=> $countones(vld_q) + 1 == $past($countones(vld_q)))
    else $error("delivered result not removed from pipeline");

  // both at once leave the fill unchanged
  a_fill_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && in_acc) |=> $countones(vld_q) == $past($countones(vld_q)))
    else $error("pipeline fill changed on pass-through");

endmodule

>>> test/vertex_affine_transform_test.sv
`timescale 1ns / 100ps
// vertex_affine_transform_test: self-checking bench for the vertex affine transform
// streams vertices, writes the registers between phases and checks every result
// depends on vat_pkg and vertex_affine_transform
module vertex_affine_transform_test;
  import vat_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int CYCLE_LIMIT    = 500000;
  // pipeline depth plus margin, waited out before any register write
  localparam int SETTLE_CYCLES  = NUM_STAGES + 4;
  // long receiver hold-off, well beyond what the five stages can absorb
  localparam int HOLD_CYCLES    = 150;
  localparam int PRESSURE_ITEMS = 40;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_VERTICES = 53;

  // q16.16 landmarks
  localparam logic signed [COORD_WIDTH-1:0] Q_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] Q_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] Q_ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [COORD_WIDTH-1:0] Q_HALF = 32'sd1 <<< (FRAC_BITS - 1);

  // codes the package leaves without a name: both pass the vertex through
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;

  // q2.16 coefficient landmarks, including the out-of-range ends
  localparam logic [TRIG_W-1:0] TRIG_MIN     = 18'h20000;
  localparam logic [TRIG_W-1:0] TRIG_MAX     = 18'h1FFFF;
  localparam logic [TRIG_W-1:0] TRIG_ONE     = 18'h10000;
  localparam logic [TRIG_W-1:0] TRIG_NEG_ONE = 18'h30000;
  localparam logic [TRIG_W-1:0] TRIG_ZERO    = 18'h00000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          last;
  } vertex_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block under test
  // ---------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]     m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  always #CLK_HALF clk_i = ~clk_i;

  vertex_affine_transform dut (.*);

  // result fields as the output item carries them, lowest bits first
  logic signed [COORD_WIDTH-1:0] got_x, got_y, got_z;
  assign got_x = m_axis_tdata[COORD_WIDTH-1:0];
  assign got_y = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign got_z = m_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  vertex_t pending_vertices[$];   // transformed vertices still to come out
  vertex_t want_vertex;
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      hold_left      = 0;    // receiver hold-off still to run, in cycles
  bit      src_idle       = 1'b1; // sender may insert gaps
  bit      sink_idle      = 1'b1; // receiver may stall

  // own copy of the register file, loaded with the reset values
  logic [MODE_W-1:0]         cur_mode  = MODE_TRANSLATE;
  logic [AXIS_W-1:0]         cur_axis  = AXIS_X;
  logic signed [OFS_W-1:0]   cur_ofs_x = '0;
  logic signed [OFS_W-1:0]   cur_ofs_y = '0;
  logic signed [OFS_W-1:0]   cur_ofs_z = '0;
  logic signed [SCALE_W-1:0] cur_scale = SCALE_RESET;
  logic signed [TRIG_W-1:0]  cur_cos   = COS_RESET;
  logic signed [TRIG_W-1:0]  cur_sin   = '0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[COORD_WIDTH-1:0];
  endfunction

  // round half up, then drop the fraction bits (floor on the shifted value)
  function automatic longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // one rotated coordinate: exact sum of two products, rounded once
  function automatic logic signed [COORD_WIDTH-1:0] turn(longint a, longint ca,
                                                         longint b, longint cb);
    return clamp_coord(round_shift(a * ca + b * cb, COEF_FRAC));
  endfunction

  function automatic vertex_t transform_vertex(vertex_t v);
    longint  x, y, z, c, s, k;
    vertex_t r;
    x = longint'(v.x);
    y = longint'(v.y);
    z = longint'(v.z);
    c = longint'(cur_cos);
    s = longint'(cur_sin);
    k = longint'(cur_scale);
    r = v;
    case (cur_mode)
      MODE_TRANSLATE: begin
        r.x = clamp_coord(x + longint'(cur_ofs_x));
        r.y = clamp_coord(y + longint'(cur_ofs_y));
        r.z = clamp_coord(z + longint'(cur_ofs_z));
      end
      MODE_SCALE: begin
        r.x = clamp_coord(round_shift(x * k, FRAC_BITS));
        r.y = clamp_coord(round_shift(y * k, FRAC_BITS));
        r.z = clamp_coord(round_shift(z * k, FRAC_BITS));
      end
      MODE_ROTATE: begin
        case (cur_axis)
          AXIS_X: begin
            r.y = turn(y, c, z, -s);
            r.z = turn(y, s, z, c);
          end
          AXIS_Y: begin
            r.x = turn(x, c, z, s);
            r.z = turn(x, -s, z, c);
          end
          AXIS_Z: begin
            r.x = turn(x, c, y, -s);
            r.y = turn(x, s, y, c);
          end
          default: ;  // spare axis code: vertex unchanged
        endcase
      end
      default: ;  // spare mode code: vertex unchanged
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one register write; the block keeps only the register's low bits
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_MODE:     cur_mode  = data[MODE_W-1:0];
      REG_AXIS:     cur_axis  = data[AXIS_W-1:0];
      REG_OFFSET_X: cur_ofs_x = data[OFS_W-1:0];
      REG_OFFSET_Y: cur_ofs_y = data[OFS_W-1:0];
      REG_OFFSET_Z: cur_ofs_z = data[OFS_W-1:0];
      REG_SCALE:    cur_scale = data[SCALE_W-1:0];
      REG_COS:      cur_cos   = data[TRIG_W-1:0];
      REG_SIN:      cur_sin   = data[TRIG_W-1:0];
      default: ;
    endcase
  endtask

  // offers one vertex item and records its expected result once accepted;
  // tvalid stays high afterwards so back-to-back items need no toggle
  task automatic offer_vertex(input logic signed [COORD_WIDTH-1:0] x,
                              input logic signed [COORD_WIDTH-1:0] y,
                              input logic signed [COORD_WIDTH-1:0] z,
                              input logic last);
    vertex_t v;
    int      gap;
    v.x    = x;
    v.y    = y;
    v.z    = z;
    v.last = last;
    gap = (src_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v.z, v.y, v.x};
    s_axis_tlast  <= v.last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_vertices.push_back(transform_vertex(v));
  endtask

  // drop tvalid, let every result drain and the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: long hold-off on request, else random stall bursts
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_vertices.size() == 0) begin
        $error("result item with no vertex pending");
        mismatch_count++;
      end else begin
        want_vertex = pending_vertices.pop_front();
        if (got_x !== want_vertex.x) begin
          $error("result_x: expected %0d, got %0d", want_vertex.x, got_x);
          mismatch_count++;
        end
        if (got_y !== want_vertex.y) begin
          $error("result_y: expected %0d, got %0d", want_vertex.y, got_y);
          mismatch_count++;
        end
        if (got_z !== want_vertex.z) begin
          $error("result_z: expected %0d, got %0d", want_vertex.z, got_z);
          mismatch_count++;
        end
        if (m_axis_tlast !== want_vertex.last) begin
          $error("end_of_mesh: expected %0b, got %0b", want_vertex.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // random values, biased towards the extremes
  // ---------------------------------------------------------------------------
  function automatic logic signed [COORD_WIDTH-1:0] random_coord();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic signed [SCALE_W-1:0] random_scale();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return Q_ONE;
      4:       return -Q_ONE;
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] random_trig();
    case ($urandom_range(0, 9))
      0:       return TRIG_MIN;
      1:       return TRIG_MAX;
      2:       return TRIG_ONE;
      3:       return TRIG_NEG_ONE;
      default: return TRIG_W'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] random_mode();
    case ($urandom_range(0, 9))
      0, 1, 2: return MODE_TRANSLATE;
      3, 4, 5: return MODE_SCALE;
      6, 7, 8: return MODE_ROTATE;
      default: return MODE_SPARE;
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] random_axis();
    case ($urandom_range(0, 6))
      0, 1:    return AXIS_X;
      2, 3:    return AXIS_Y;
      4, 5:    return AXIS_Z;
      default: return AXIS_SPARE;
    endcase
  endfunction

  // random bits above a narrow register's width, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] val, int w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (w >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << w) - 1'b1);
    return (CFG_DATA_W'($urandom) & ~mask) | (val & mask);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // reset values: zero offsets, scale 1.0, cos 1.0 and sin 0 about x
  task automatic test_reset_values();
    offer_vertex(Q_ONE, -Q_ONE, 3 * Q_ONE + 5, 1'b0);
    wait_idle();
    write_reg(REG_MODE, MODE_SCALE);
    offer_vertex(32'sh0001_2345, Q_MIN, Q_MAX, 1'b1);
    wait_idle();
    write_reg(REG_MODE, MODE_ROTATE);
    offer_vertex(Q_MAX, -7, Q_MIN, 1'b0);
  endtask

  // translation with sums that clamp at both ends
  task automatic test_translate();
    wait_idle();
    write_reg(REG_MODE, MODE_TRANSLATE);
    write_reg(REG_OFFSET_X, Q_MAX);
    write_reg(REG_OFFSET_Y, Q_MIN);
    write_reg(REG_OFFSET_Z, Q_ONE);
    offer_vertex(Q_MAX, Q_MIN, -5, 1'b0);
    offer_vertex(Q_MIN, Q_MAX, Q_MAX, 1'b1);
    offer_vertex('0, '0, '0, 1'b0);
  endtask

  // scaling: half-way ties in both signs, and products that clamp
  task automatic test_scale();
    wait_idle();
    write_reg(REG_MODE, MODE_SCALE);
    write_reg(REG_SCALE, Q_HALF);
    offer_vertex(1, -1, 3, 1'b0);
    offer_vertex(-3, Q_MAX, Q_MIN, 1'b1);
    wait_idle();
    write_reg(REG_SCALE, Q_MAX);
    offer_vertex(Q_MAX, Q_MIN, Q_ONE, 1'b0);
    wait_idle();
    write_reg(REG_SCALE, Q_MIN);
    offer_vertex(Q_MIN, Q_MAX, -Q_ONE, 1'b1);
    wait_idle();
    write_reg(REG_SCALE, -Q_ONE);
    offer_vertex(Q_MIN, Q_MAX, 0, 1'b0);
  endtask

  // quarter turn about each axis, then coefficients beyond +-1.0
  task automatic test_rotate();
    wait_idle();
    write_reg(REG_MODE, MODE_ROTATE);
    write_reg(REG_COS, {14'h2A5A, TRIG_ZERO});
    write_reg(REG_SIN, {14'h1234, TRIG_ONE});
    write_reg(REG_AXIS, AXIS_X);
    offer_vertex(3 * Q_ONE, -2 * Q_ONE + 12345, Q_HALF + 1, 1'b0);
    wait_idle();
    write_reg(REG_AXIS, AXIS_Y);
    offer_vertex(3 * Q_ONE, -2 * Q_ONE + 12345, Q_HALF + 1, 1'b1);
    wait_idle();
    write_reg(REG_AXIS, AXIS_Z);
    offer_vertex(3 * Q_ONE, -2 * Q_ONE + 12345, Q_HALF + 1, 1'b0);
    wait_idle();
    write_reg(REG_COS, {14'h3FFF, TRIG_MIN});
    write_reg(REG_SIN, {14'h0000, TRIG_MAX});
    offer_vertex(Q_MAX, Q_MIN, Q_MAX, 1'b1);
    wait_idle();
    write_reg(REG_AXIS, AXIS_X);
    offer_vertex(Q_MIN, Q_MAX, Q_MIN, 1'b0);
    wait_idle();
    write_reg(REG_AXIS, AXIS_Y);
    offer_vertex(Q_MAX, Q_MAX, Q_MIN, 1'b1);
  endtask

  // spare mode and spare axis codes pass the vertex through
  task automatic test_spare_codes();
    wait_idle();
    write_reg(REG_MODE, {{(CFG_DATA_W-MODE_W){1'b1}}, MODE_SPARE});
    offer_vertex(Q_MAX, Q_MIN, -1, 1'b1);
    wait_idle();
    write_reg(REG_MODE, {{(CFG_DATA_W-MODE_W){1'b1}}, MODE_ROTATE});
    write_reg(REG_AXIS, {{(CFG_DATA_W-AXIS_W){1'b1}}, AXIS_SPARE});
    offer_vertex(Q_MIN, 12345, Q_MAX, 1'b0);
  endtask

  // receiver holds off long enough for all stages to fill and stall the input
  task automatic test_pressure();
    wait_idle();
    write_reg(REG_MODE, MODE_SCALE);
    write_reg(REG_SCALE, -3 * Q_HALF);
    src_idle  = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (PRESSURE_ITEMS)
      offer_vertex(random_coord(), random_coord(), random_coord(), 1'($urandom));
    src_idle = 1'b1;
  endtask

  // random settings per phase with random vertices; stretches without gaps
  // or stalls in the middle and at the end
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      src_idle  = !(p == 6 || p >= RANDOM_PHASES - 3);
      sink_idle = src_idle;
      write_reg(REG_MODE,     with_junk(random_mode(), MODE_W));
      write_reg(REG_AXIS,     with_junk(random_axis(), AXIS_W));
      write_reg(REG_OFFSET_X, random_coord());
      write_reg(REG_OFFSET_Y, random_coord());
      write_reg(REG_OFFSET_Z, random_coord());
      write_reg(REG_SCALE,    random_scale());
      write_reg(REG_COS,      with_junk(random_trig(), TRIG_W));
      write_reg(REG_SIN,      with_junk(random_trig(), TRIG_W));
      repeat (PHASE_VERTICES)
        offer_vertex(random_coord(), random_coord(), random_coord(), 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_translate();
    test_scale();
    test_rotate();
    test_spare_codes();
    test_pressure();
    test_random_phases();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vat_pkg.sv
rtl/vat_operand_sel.sv
rtl/vat_mac_lane.sv
rtl/vertex_affine_transform.sv
test/vertex_affine_transform_test.sv
